// File: design/dnhl_pkg.sv
`timescale 1ns / 1ps

package dnhl_pkg;

    localparam int ANGLE_W = 19;
    localparam int CNT_W = 7;
    localparam int HOLE_IDX_W = 6;
    localparam int DIFF_W = 21;
    localparam int CFG_ADDR_W = 3;

    localparam int MAX_HOLES_DEF = 64;
    localparam int MATCH_TOLERANCE_DEF = 5;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 19'd359999;
    localparam logic [ANGLE_W:0] FULL_TURN = 20'd360000;

    localparam logic [ANGLE_W-1:0] RST_FIRST_HOLE_ANGLE = 19'd0;
    localparam logic [ANGLE_W-1:0] RST_INNER_PITCH = 19'd10000;
    localparam logic [ANGLE_W-1:0] RST_SECTOR_PITCH = 19'd15000;
    localparam logic [CNT_W-1:0] RST_HOLES_PER_SECTOR = 7'd8;
    localparam logic [CNT_W-1:0] RST_HOLE_COUNT = 7'd32;
    localparam logic [ANGLE_W-1:0] RST_SENSOR_SPACING = 19'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_HOLE_ANGLE = 3'd0,
        REG_INNER_PITCH = 3'd1,
        REG_SECTOR_PITCH = 3'd2,
        REG_HOLES_PER_SECTOR = 3'd3,
        REG_HOLE_COUNT = 3'd4,
        REG_SENSOR_SPACING = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [ANGLE_W-1:0] first_hole_angle;
        logic [ANGLE_W-1:0] inner_pitch;
        logic [ANGLE_W-1:0] sector_pitch;
        logic [CNT_W-1:0] holes_per_sector;
        logic [CNT_W-1:0] hole_count;
        logic [ANGLE_W-1:0] sensor_spacing;
    } cfg_t;

    // One request travelling down the row of cells.
    typedef struct packed {
        logic valid;
        logic found;
        logic [HOLE_IDX_W-1:0] idx;
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] offset;
    } item_t;

    // Table rebuild wave: each cell after cell 0 derives its hole angle from its neighbor.
    typedef struct packed {
        logic wave;
        logic [ANGLE_W-1:0] hole_angle;
        logic [CNT_W-1:0] sector_pos;
    } build_t;

endpackage

// File: design/dnhl_front.sv
`timescale 1ns / 1ps

module dnhl_front
    import dnhl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [ANGLE_W-1:0] angle,
    input  logic               mode,
    input  logic [ANGLE_W-1:0] sensor_spacing,
    output item_t              item_out
);

    localparam logic signed [DIFF_W-1:0] FULL_S = DIFF_W'(FULL_TURN);
    localparam logic signed [DIFF_W-1:0] TWO_FULL_S = DIFF_W'(2 * FULL_TURN);

    logic                      valid_a_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DIFF_W-1:0]  diff_next;
    item_t                     item_reg;
    item_t                     item_next;
    logic signed [DIFF_W-1:0]  wrapped;

    always_comb
    begin
        diff_next = $signed({2'b00, angle});
        if (mode)
        begin
            diff_next = $signed({2'b00, angle}) - $signed({2'b00, sensor_spacing});
        end
    end

    always_comb
    begin
        if (diff_reg >= FULL_S)
        begin
            wrapped = diff_reg - FULL_S;
        end
        else if (diff_reg >= 0)
        begin
            wrapped = diff_reg;
        end
        else if (diff_reg >= -FULL_S)
        begin
            wrapped = diff_reg + FULL_S;
        end
        else
        begin
            wrapped = diff_reg + TWO_FULL_S;
        end
        item_next = '0;
        item_next.valid = valid_a_reg;
        item_next.angle = wrapped[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            diff_reg <= '0;
            item_reg <= '0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            diff_reg <= diff_next;
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// File: design/dnhl_cell.sv
`timescale 1ns / 1ps

module dnhl_cell
    import dnhl_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int MATCH_TOLERANCE = MATCH_TOLERANCE_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  cfg_t   cfg,
    input  build_t build_in,
    output build_t build_out,
    input  item_t  item_in,
    output item_t  item_out
);

    logic               wave_reg;
    logic [ANGLE_W-1:0] hole_angle_reg;
    logic [ANGLE_W-1:0] hole_angle_next;
    logic [CNT_W-1:0]   sector_pos_reg;
    logic [CNT_W-1:0]   sector_pos_next;
    logic [CNT_W-1:0]   pos_inc;
    logic [ANGLE_W-1:0] step;
    logic [ANGLE_W:0]   sum;
    item_t              item_reg;
    item_t              item_next;
    logic               active;
    logic               hit;
    logic [ANGLE_W-1:0] hole_dist;

    always_comb
    begin
        pos_inc = build_in.sector_pos + 1'b1;
        step = cfg.inner_pitch;
        sum = '0;
        if (INDEX == 0)
        begin
            sector_pos_next = '0;
            hole_angle_next = (cfg.first_hole_angle > ANGLE_MAX) ? ANGLE_MAX
                                                                  : cfg.first_hole_angle;
        end
        else
        begin
            sector_pos_next = (pos_inc == cfg.holes_per_sector) ? '0 : pos_inc;
            if ((cfg.holes_per_sector > 7'd1) && (sector_pos_next == '0))
            begin
                step = cfg.sector_pitch;
            end
            sum = {1'b0, build_in.hole_angle} + {1'b0, step};
            hole_angle_next = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= 1'b0;
        end
        else
        begin
            wave_reg <= build_in.wave;
        end
    end

    always_ff @(posedge clk)
    begin
        if (build_in.wave)
        begin
            hole_angle_reg <= hole_angle_next;
            sector_pos_reg <= sector_pos_next;
        end
    end

    assign build_out.wave = wave_reg;
    assign build_out.hole_angle = hole_angle_reg;
    assign build_out.sector_pos = sector_pos_reg;

    assign active = (INDEX == 0) || (int'(cfg.hole_count) > INDEX);
    assign hit = ({1'b0, hole_angle_reg} + (ANGLE_W + 1)'(MATCH_TOLERANCE))
                 >= {1'b0, item_in.angle};
    assign hole_dist = (item_in.angle > hole_angle_reg) ? (item_in.angle - hole_angle_reg)
                                                        : (hole_angle_reg - item_in.angle);

    always_comb
    begin
        item_next = item_in;
        if (item_in.valid && !item_in.found && active && hit)
        begin
            item_next.found = 1'b1;
            item_next.idx = HOLE_IDX_W'(INDEX);
            item_next.offset = hole_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// File: design/disk_next_hole_locator_unit.sv
// Slotted-disk next-hole locator. Each request carries an angle in thousandths
// of a degree and a sensor select; the result is the index of the first hole at
// or after that angle (within MATCH_TOLERANCE units) and the absolute distance
// to it, wrapping to hole 0 one turn later when no hole is left. One request is
// taken every cycle while the output register is empty or out_ready is high. A
// request passes the sensor offset register and the wrap register, one cell per
// hole in the comparison row, and the output register. After reset and after every
// configuration write the hole table is rebuilt by a wave that walks the row
// one cell per cycle ahead of any later request, so no request has to wait.
`timescale 1ns / 1ps

module disk_next_hole_locator_unit
    import dnhl_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF,
    parameter int MATCH_TOLERANCE = MATCH_TOLERANCE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ANGLE_W-1:0]    angle,
    input  logic                  mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [HOLE_IDX_W-1:0] hole_index,
    output logic [ANGLE_W-1:0]    offset,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ANGLE_W-1:0]    cfg_wdata
);

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  build_start_reg;
    logic                  en;
    item_t                 item_chain [MAX_HOLES+1];
    build_t                build_chain [MAX_HOLES+1];
    item_t                 last;
    logic                  out_valid_reg;
    logic [HOLE_IDX_W-1:0] hole_index_reg;
    logic [HOLE_IDX_W-1:0] hole_index_next;
    logic [ANGLE_W-1:0]    offset_reg;
    logic [ANGLE_W-1:0]    offset_next;
    logic [ANGLE_W:0]      wrap_sum;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_FIRST_HOLE_ANGLE: cfg_next.first_hole_angle = cfg_wdata;
                REG_INNER_PITCH: cfg_next.inner_pitch = cfg_wdata;
                REG_SECTOR_PITCH: cfg_next.sector_pitch = cfg_wdata;
                REG_HOLES_PER_SECTOR: cfg_next.holes_per_sector = cfg_wdata[CNT_W-1:0];
                REG_HOLE_COUNT: cfg_next.hole_count = cfg_wdata[CNT_W-1:0];
                REG_SENSOR_SPACING: cfg_next.sensor_spacing = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_hole_angle <= RST_FIRST_HOLE_ANGLE;
            cfg_reg.inner_pitch <= RST_INNER_PITCH;
            cfg_reg.sector_pitch <= RST_SECTOR_PITCH;
            cfg_reg.holes_per_sector <= RST_HOLES_PER_SECTOR;
            cfg_reg.hole_count <= RST_HOLE_COUNT;
            cfg_reg.sensor_spacing <= RST_SENSOR_SPACING;
            build_start_reg <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
            build_start_reg <= cfg_wr_en;
        end
    end

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign build_chain[0].wave = build_start_reg;
    assign build_chain[0].hole_angle = '0;
    assign build_chain[0].sector_pos = '0;

    dnhl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .angle          (angle),
        .mode           (mode),
        .sensor_spacing (cfg_reg.sensor_spacing),
        .item_out       (item_chain[0])
    );

    for (genvar g = 0; g < MAX_HOLES; g++)
    begin : g_cell
        dnhl_cell #(
            .INDEX           (g),
            .MATCH_TOLERANCE (MATCH_TOLERANCE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cfg       (cfg_reg),
            .build_in  (build_chain[g]),
            .build_out (build_chain[g+1]),
            .item_in   (item_chain[g]),
            .item_out  (item_chain[g+1])
        );
    end

    assign last = item_chain[MAX_HOLES];
    assign wrap_sum = {1'b0, build_chain[1].hole_angle} + FULL_TURN - {1'b0, last.angle};

    always_comb
    begin
        if (last.found)
        begin
            hole_index_next = last.idx;
            offset_next = last.offset;
        end
        else
        begin
            hole_index_next = '0;
            offset_next = wrap_sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hole_index_reg <= hole_index_next;
            offset_reg <= offset_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hole_index = hole_index_reg;
    assign offset = offset_reg;

endmodule
